// File: hw/rtl/jsmc_pkg.sv
// ----------------------------------------------------------------------------
// jsmc_pkg
// Types, codes and constants of the three-joint servo mode controller.
// ----------------------------------------------------------------------------
package jsmc_pkg;

    localparam int NJ           = 3;   // local joints handled by this block
    localparam int LOCAL_JOINTS = 3;   // joints per node in the global numbering
    localparam int LIDX_W       = 3;   // holds any local index for 1..8 joints per node
    localparam int POT_W        = 10;
    localparam int GAIN_W       = 16;
    localparam int DRIVE_W      = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [POT_W-1:0] NAT_LOW    = 10'd10;
    localparam logic [POT_W-1:0] NAT_HIGH   = 10'd1014;
    localparam logic [POT_W:0]   OOR_MARGIN = 11'd4;

    localparam logic [DRIVE_W-1:0] ZERO_DRIVE = 8'd128;
    localparam logic [DRIVE_W-1:0] MIN_DRIVE  = 8'd27;
    localparam logic [DRIVE_W-1:0] MAX_DRIVE  = 8'd229;

    typedef enum logic [1:0] {
        MODE_WAIT     = 2'd0,
        MODE_CAL      = 2'd1,
        MODE_HOLD_ONE = 2'd2,
        MODE_HOLD_ALL = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        CMD_ID        = 4'd0,
        CMD_START_CAL = 4'd1,
        CMD_STOP_CAL  = 4'd2,
        CMD_GET_CAL   = 4'd3,
        CMD_SEND_TRAJ = 4'd4,
        CMD_HOLD_ONE  = 4'd5,
        CMD_HOLD_ALL  = 4'd6,
        CMD_TRAJ_A    = 4'd7,
        CMD_TRAJ_B    = 4'd8,
        CMD_STOP      = 4'd9,
        CMD_WAIT      = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_BAD_CMD     = 2'd1,
        STS_JOINT_RANGE = 2'd2,
        STS_POT_RANGE   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_A    = 2'd0,
        CFG_GAIN_B    = 2'd1,
        CFG_GAIN_C    = 2'd2,
        CFG_DIRECTION = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        REQ_COMMAND = 1'b0,
        REQ_TICK    = 1'b1
    } t_req_type;

    typedef struct packed {
        logic             req_type;
        logic [3:0]       command_code;
        logic [3:0]       joint_number;
        logic [POT_W-1:0] pot_a;
        logic [POT_W-1:0] pot_b;
        logic [POT_W-1:0] pot_c;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic [NJ-1:0]      enable_bits;
        logic [NJ-1:0]      drive_valid_bits;
        logic [DRIVE_W-1:0] drive_a;
        logic [DRIVE_W-1:0] drive_b;
        logic [DRIVE_W-1:0] drive_c;
        logic               report_valid;
        logic [POT_W-1:0]   report_min;
        logic [POT_W-1:0]   report_max;
    } t_result;

    // global joint number -> local index, (n-1) mod LOCAL_JOINTS; zero wraps to the top
    function automatic logic [LIDX_W-1:0] local_index(input logic [3:0] num);
        logic [LIDX_W-1:0] r;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            if (num == 4'(k)) begin
                r = LIDX_W'((k + LOCAL_JOINTS - 1) % LOCAL_JOINTS);
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/joint_servo_mode_controller.sv
// ----------------------------------------------------------------------------
// joint_servo_mode_controller
// Mode controller for three servo joints: calibration, hold and P drive.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle when the result side does not stall; an item
// goes from the input register through the single-pass decode / limit check /
// P drive into the result register. Mode, limits, hold targets and calibration
// range are updated in the cycle the item moves into the result register, so
// the next item sees them at once.
// Configuration writes are always taken (ready is tied high).
module joint_servo_mode_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  jsmc_pkg::t_request                i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output jsmc_pkg::t_result                 o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jsmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jsmc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import jsmc_pkg::*;

    // pipeline control
    logic     r_in_valid;
    t_request r_in;
    logic     r_out_valid;
    t_result  r_out;
    logic     out_take;
    logic     fire;
    logic     in_acc;

    // configuration
    logic [GAIN_W-1:0] r_gain [NJ];
    logic [NJ-1:0]     r_dir;

    // block state
    t_mode            r_mode, n_mode;
    logic [1:0]       r_sel, n_sel;
    logic [POT_W-1:0] r_target [NJ];
    logic [POT_W-1:0] n_target [NJ];
    logic [POT_W-1:0] r_lim_lo [NJ];
    logic [POT_W-1:0] n_lim_lo [NJ];
    logic [POT_W-1:0] r_lim_hi [NJ];
    logic [POT_W-1:0] n_lim_hi [NJ];
    logic [POT_W-1:0] r_cal_min, n_cal_min;
    logic [POT_W-1:0] r_cal_max, n_cal_max;
    logic [NJ-1:0]    r_enables, n_enables;

    // decode
    logic [POT_W-1:0]  pot [NJ];
    t_cmd              cmd;
    logic [LIDX_W-1:0] lidx;
    logic              lidx_ok;
    logic [1:0]        lsel;
    logic              cmd_rej;
    logic              hold_active;
    logic [NJ-1:0]     hold_mask;
    logic [NJ-1:0]     oor;
    logic              hold_bad;
    logic [POT_W-1:0]  cal_pot;
    logic              nat_bad;

    // drive datapath
    logic signed [POT_W:0]     err  [NJ];
    logic [POT_W-1:0]          mag  [NJ];
    logic [POT_W+GAIN_W-1:0]   prod [NJ];
    logic [POT_W+GAIN_W-9:0]   pmag [NJ];
    logic                      neg  [NJ];
    logic [DRIVE_W-1:0]        drive [NJ];

    t_result res;

    assign out_take    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_take;
    assign o_in_stall  = r_in_valid && !out_take;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign pot[0] = r_in.pot_a;
    assign pot[1] = r_in.pot_b;
    assign pot[2] = r_in.pot_c;

    assign cmd     = t_cmd'(r_in.command_code);
    assign lidx    = local_index(r_in.joint_number);
    assign lidx_ok = lidx < LIDX_W'(NJ);
    assign lsel    = lidx[1:0];

    assign hold_active = (r_mode == MODE_HOLD_ONE) || (r_mode == MODE_HOLD_ALL);
    assign hold_mask   = (r_mode == MODE_HOLD_ONE) ? (NJ'(1) << r_sel) : '1;
    assign hold_bad    = |(oor & hold_mask);

    assign cal_pot = pot[r_sel];
    assign nat_bad = (cal_pot < NAT_LOW) || (cal_pot > NAT_HIGH);

    // command acceptance by mode
    always_comb begin
        unique case (cmd)
            CMD_ID:                      cmd_rej = (r_mode != MODE_WAIT);
            CMD_START_CAL, CMD_HOLD_ONE: cmd_rej = (r_mode != MODE_WAIT) || !lidx_ok;
            CMD_STOP_CAL:                cmd_rej = (r_mode != MODE_CAL);
            CMD_HOLD_ALL:                cmd_rej = (r_mode != MODE_WAIT);
            default:                     cmd_rej = 1'b0;
        endcase
    end

    // limit check and P drive per joint
    always_comb begin
        for (int j = 0; j < NJ; j++) begin
            oor[j] = ({1'b0, pot[j]} < ({1'b0, r_lim_lo[j]} + OOR_MARGIN))
                  || (({1'b0, pot[j]} + OOR_MARGIN) > {1'b0, r_lim_hi[j]});
            err[j]  = $signed({1'b0, r_target[j]}) - $signed({1'b0, pot[j]});
            mag[j]  = err[j][POT_W] ? POT_W'(-err[j]) : err[j][POT_W-1:0];
            prod[j] = (POT_W+GAIN_W)'(mag[j]) * (POT_W+GAIN_W)'(r_gain[j]);
            pmag[j] = prod[j][POT_W+GAIN_W-1:8];
            neg[j]  = err[j][POT_W] ^ !r_dir[j];
            if (neg[j]) begin
                if (pmag[j] > (POT_W+GAIN_W-8)'(ZERO_DRIVE - MIN_DRIVE)) begin
                    drive[j] = MIN_DRIVE;
                end else begin
                    drive[j] = ZERO_DRIVE - pmag[j][DRIVE_W-1:0];
                end
            end else begin
                if (pmag[j] > (POT_W+GAIN_W-8)'(MAX_DRIVE - ZERO_DRIVE)) begin
                    drive[j] = MAX_DRIVE;
                end else begin
                    drive[j] = ZERO_DRIVE + pmag[j][DRIVE_W-1:0];
                end
            end
        end
    end

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_sel     = r_sel;
        n_target  = r_target;
        n_lim_lo  = r_lim_lo;
        n_lim_hi  = r_lim_hi;
        n_cal_min = r_cal_min;
        n_cal_max = r_cal_max;
        n_enables = r_enables;
        if (fire) begin
            if (r_in.req_type == REQ_COMMAND) begin
                if (!cmd_rej) begin
                    unique case (cmd)
                        CMD_START_CAL: begin
                            n_sel     = lsel;
                            n_cal_min = pot[lsel];
                            n_cal_max = pot[lsel];
                            n_mode    = MODE_CAL;
                        end
                        CMD_STOP_CAL: begin
                            n_lim_lo[r_sel] = r_cal_min;
                            n_lim_hi[r_sel] = r_cal_max;
                            n_mode          = MODE_WAIT;
                        end
                        CMD_HOLD_ONE: begin
                            n_sel           = lsel;
                            n_target[lsel]  = pot[lsel];
                            n_enables       = r_enables | (NJ'(1) << lsel);
                            n_mode          = MODE_HOLD_ONE;
                        end
                        CMD_HOLD_ALL: begin
                            n_target  = pot;
                            n_enables = '1;
                            n_mode    = MODE_HOLD_ALL;
                        end
                        CMD_STOP: begin
                            n_enables = '0;
                            n_mode    = MODE_WAIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                unique case (r_mode)
                    MODE_CAL: begin
                        if (cal_pot < r_cal_min) begin
                            n_cal_min = cal_pot;
                        end else if (cal_pot > r_cal_max) begin
                            n_cal_max = cal_pot;
                        end
                    end
                    MODE_HOLD_ONE, MODE_HOLD_ALL: begin
                        if (hold_bad) begin
                            n_enables = '0;
                            n_mode    = MODE_WAIT;
                        end
                    end
                    MODE_WAIT: begin
                    end
                endcase
            end
        end
    end

    // result fields
    always_comb begin
        logic [NJ-1:0] dvalid;
        dvalid           = '0;
        res.status       = STS_OK;
        res.report_valid = 1'b0;
        res.report_min   = '0;
        res.report_max   = '0;
        if (r_in.req_type == REQ_COMMAND) begin
            if (cmd_rej) begin
                res.status = STS_BAD_CMD;
            end else if (cmd == CMD_STOP_CAL) begin
                res.report_valid = 1'b1;
                res.report_min   = r_cal_min;
                res.report_max   = r_cal_max;
            end
        end else if (r_mode == MODE_CAL) begin
            if (nat_bad) begin
                res.status = STS_POT_RANGE;
            end
        end else if (hold_active) begin
            if (hold_bad) begin
                res.status = STS_JOINT_RANGE;
            end else begin
                dvalid = hold_mask;
            end
        end
        res.enable_bits      = n_enables;
        res.drive_valid_bits = dvalid;
        res.drive_a          = dvalid[0] ? drive[0] : ZERO_DRIVE;
        res.drive_b          = dvalid[1] ? drive[1] : ZERO_DRIVE;
        res.drive_c          = dvalid[2] ? drive[2] : ZERO_DRIVE;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_WAIT;
            r_sel       <= '0;
            r_cal_min   <= '0;
            r_cal_max   <= '0;
            r_enables   <= '0;
            r_dir       <= '1;
            for (int j = 0; j < NJ; j++) begin
                r_gain[j]   <= GAIN_W'(256);
                r_target[j] <= '0;
                r_lim_lo[j] <= '0;
                r_lim_hi[j] <= '1;
            end
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_GAIN_A:    r_gain[0] <= i_cfg_data;
                    CFG_GAIN_B:    r_gain[1] <= i_cfg_data;
                    CFG_GAIN_C:    r_gain[2] <= i_cfg_data;
                    CFG_DIRECTION: r_dir     <= i_cfg_data[NJ-1:0];
                endcase
            end
            r_mode    <= n_mode;
            r_sel     <= n_sel;
            r_target  <= n_target;
            r_lim_lo  <= n_lim_lo;
            r_lim_hi  <= n_lim_hi;
            r_cal_min <= n_cal_min;
            r_cal_max <= n_cal_max;
            r_enables <= n_enables;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    // motors only run while holding
    a_enables_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_WAIT || r_mode == MODE_CAL) |-> (r_enables == '0))
        else $error("enables set outside hold mode");

    // a new drive value never comes with an error status
    a_drive_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.drive_valid_bits != '0) |-> (o_out_data.status == STS_OK))
        else $error("drive valid with error status");

    // calibration report is ordered and carries no error
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.report_valid)
        |-> (o_out_data.status == STS_OK && o_out_data.report_min <= o_out_data.report_max))
        else $error("bad calibration report");

    // an idle drive_a field reads zero torque
    a_drive_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.drive_valid_bits[0]) |-> (o_out_data.drive_a == ZERO_DRIVE))
        else $error("drive_a not at zero torque when not valid");

    // an item in the input register moves on whenever the result side is free
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_out_stall) |=> r_out_valid)
        else $error("pending item not transferred");

endmodule
